FILE: rtl/opep_pkg.sv
// Package: shared types and constants of the out-of-band packet envelope parser.
`timescale 1ns / 1ps
`default_nettype none
package opep_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 6;
  localparam int OFFSET_W   = 15;
  localparam int HDR_LEN    = 4;
  localparam int MIN_PACKET = 5;
  localparam int TOKEN_CAP  = 32;
  localparam int WORD_LEN   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic [BYTE_W-1:0] CH_HDR   = 8'hFF;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h70;
  localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_G     = 8'h67;

  typedef enum logic [3:0] {
    CLS_HDR,
    CLS_BLANK,
    CLS_BREAK,
    CLS_P,
    CLS_I,
    CLS_N,
    CLS_O,
    CLS_G,
    CLS_OTHER
  } byte_class_e;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_SKIP,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNDERSIZED,
    ST_NO_HEADER,
    ST_BAD_LENGTH,
    ST_UNKNOWN,
    ST_TOO_LONG
  } status_e;

  typedef enum logic {
    CMD_PING,
    CMD_PONG
  } command_e;

  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    command_e            command_id;
    logic [OFFSET_W-1:0] payload_offset;
    logic [OFFSET_W-1:0] payload_length;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/oob_packet_envelope_parser_unit.sv
// Top level: out-of-band packet envelope parser with queue interfaces.
// Throughput: one packet byte per clock cycle, sustained, with both queues flowing.
// Path: a final byte is written into the item queue, parsed as it leaves that queue, and its
//   result is written into the result queue, whose head drives result_o (empty low).
// Two-entry queues, front to back and ahead of the results, let either side stall alone.
// Reset (asynchronous, rst_ni low): queues empty, parse state at header phase,
//   max command length back to 32. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module oob_packet_envelope_parser_unit #(
  parameter int MAX_PACKET_BYTES = 16384
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // byte input queue
  input  wire logic                        push,
  output logic                             full,
  input  wire opep_pkg::in_item_t          in_i,
  // result queue
  output logic                             empty,
  input  wire logic                        pop,
  output opep_pkg::result_t                result_o,
  // configuration write channel: max command length
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [opep_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int PosW  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ClsW  = $bits(opep_pkg::byte_class_e);
  // Queue entry: class, last mark, position, overflow flag.
  localparam int QW    = ClsW + 1 + PosW + 1;
  localparam int ResW  = $bits(opep_pkg::result_t);

  logic [opep_pkg::CFG_W-1:0] max_len_q;

  opep_pkg::byte_class_e f_cls;
  logic                  f_last, f_too_long, f_push;
  logic [PosW-1:0]       f_pos;

  logic                  q_full, q_empty, q_pop;
  logic [QW-1:0]         q_wdata, q_rdata;

  logic                  r_full, r_push;
  opep_pkg::result_t     r_data;
  logic [ResW-1:0]       r_rdata;

  // The register takes a write every cycle; the user must write it only while idle; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= opep_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Front: take the byte, classify it and stamp its position.
  opep_front #(
    .MaxPacketBytes (MAX_PACKET_BYTES),
    .PosW           (PosW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_i),
    .full_o     (full),
    .q_full_i   (q_full),
    .q_push_o   (f_push),
    .cls_o      (f_cls),
    .last_o     (f_last),
    .pos_o      (f_pos),
    .too_long_o (f_too_long)
  );

  assign q_wdata = {f_cls, f_last, f_pos, f_too_long};

  // Decoupling queue between classification and parsing.
  opep_fifo #(
    .Width (QW),
    .Depth (opep_pkg::QUEUE_DEPTH)
  ) u_item_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (f_push),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  // Back: advance the parse state; on the final byte emit one result.
  opep_back #(
    .MaxPacketBytes (MAX_PACKET_BYTES),
    .PosW           (PosW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_cmd_len_i (max_len_q),
    .item_valid_i  (!q_empty),
    .cls_i         (opep_pkg::byte_class_e'(q_rdata[QW-1 -: ClsW])),
    .last_i        (q_rdata[PosW+1]),
    .pos_i         (q_rdata[PosW:1]),
    .too_long_i    (q_rdata[0]),
    .item_pop_o    (q_pop),
    .res_full_i    (r_full),
    .res_push_o    (r_push),
    .res_o         (r_data)
  );

  // Result queue; its head drives the result ports.
  opep_fifo #(
    .Width (ResW),
    .Depth (opep_pkg::QUEUE_DEPTH)
  ) u_result_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (r_push),
    .wr_data_i (r_data),
    .full_o    (r_full),
    .rd_en_i   (pop),
    .rd_data_o (r_rdata),
    .empty_o   (empty)
  );

  assign result_o = opep_pkg::result_t'(r_rdata);

endmodule
`default_nettype wire

FILE: rtl/opep_fifo.sv
// Small register queue with registered storage, used between the parser stages and ahead of the results.
`timescale 1ns / 1ps
`default_nettype none
module opep_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic      [Width-1:0] rd_data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/opep_front.sv
// Front end: accepts packet bytes, classifies them and tracks the byte position.
`timescale 1ns / 1ps
`default_nettype none
module opep_front #(
  parameter int MaxPacketBytes = 16384,
  parameter int PosW = $clog2(MaxPacketBytes + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire opep_pkg::in_item_t     item_i,
  output logic                        full_o,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output opep_pkg::byte_class_e       cls_o,
  output logic                        last_o,
  output logic [PosW-1:0]             pos_o,
  output logic                        too_long_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            accept;

  assign full_o     = q_full_i;
  assign accept     = push_i && !q_full_i;
  assign q_push_o   = accept;
  assign last_o     = item_i.last_byte;
  assign pos_o      = pos_q;
  // Position saturates at the limit, so equality marks the overflow.
  assign too_long_o = (pos_q == PosW'(MaxPacketBytes));

  always_comb begin
    unique case (item_i.packet_byte) inside
      opep_pkg::CH_HDR:                   cls_o = opep_pkg::CLS_HDR;
      opep_pkg::CH_SPACE, opep_pkg::CH_TAB: cls_o = opep_pkg::CLS_BLANK;
      opep_pkg::CH_LF, opep_pkg::CH_NUL:  cls_o = opep_pkg::CLS_BREAK;
      opep_pkg::CH_P:                     cls_o = opep_pkg::CLS_P;
      opep_pkg::CH_I:                     cls_o = opep_pkg::CLS_I;
      opep_pkg::CH_N:                     cls_o = opep_pkg::CLS_N;
      opep_pkg::CH_O:                     cls_o = opep_pkg::CLS_O;
      opep_pkg::CH_G:                     cls_o = opep_pkg::CLS_G;
      default:                            cls_o = opep_pkg::CLS_OTHER;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (item_i.last_byte) begin
        pos_d = '0;
      end else if (!too_long_o) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/opep_back.sv
// Back end: parse state machine over classified bytes and result formation.
`timescale 1ns / 1ps
`default_nettype none
module opep_back #(
  parameter int MaxPacketBytes = 16384,
  parameter int PosW = $clog2(MaxPacketBytes + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [opep_pkg::CFG_W-1:0]     max_cmd_len_i,
  input  wire logic                           item_valid_i,
  input  wire opep_pkg::byte_class_e          cls_i,
  input  wire logic                           last_i,
  input  wire logic [PosW-1:0]                pos_i,
  input  wire logic                           too_long_i,
  output logic                                item_pop_o,
  input  wire logic                           res_full_i,
  output logic                                res_push_o,
  output opep_pkg::result_t                   res_o
);

  localparam int TlW  = opep_pkg::CFG_W;
  localparam int ExtW = (PosW > opep_pkg::OFFSET_W) ? PosW : opep_pkg::OFFSET_W;

  opep_pkg::phase_e phase_q, phase_d;
  logic             hdr_good_q, hdr_good_d;
  logic [TlW-1:0]   tok_len_q, tok_len_d;
  logic             ping_q, ping_d;
  logic             pong_q, pong_d;
  logic [PosW-1:0]  pstart_q, pstart_d;

  opep_pkg::byte_class_e ping_exp, pong_exp;
  logic [PosW-1:0]  pos_next;
  logic [TlW-1:0]   limit;
  logic [PosW-1:0]  off_w, len_w;
  logic [ExtW-1:0]  off_ext, len_ext;

  assign item_pop_o = item_valid_i && (!last_i || !res_full_i);
  assign res_push_o = item_pop_o && last_i;
  assign pos_next   = pos_i + PosW'(1);

  // Expected letter at the current token index.
  always_comb begin
    unique case (tok_len_q[1:0])
      2'd0: begin
        ping_exp = opep_pkg::CLS_P;
        pong_exp = opep_pkg::CLS_P;
      end
      2'd1: begin
        ping_exp = opep_pkg::CLS_I;
        pong_exp = opep_pkg::CLS_O;
      end
      2'd2: begin
        ping_exp = opep_pkg::CLS_N;
        pong_exp = opep_pkg::CLS_N;
      end
      default: begin
        ping_exp = opep_pkg::CLS_G;
        pong_exp = opep_pkg::CLS_G;
      end
    endcase
  end

  // Next parse state for the byte at the head of the queue.
  always_comb begin
    phase_d    = phase_q;
    hdr_good_d = hdr_good_q;
    tok_len_d  = tok_len_q;
    ping_d     = ping_q;
    pong_d     = pong_q;
    pstart_d   = pstart_q;
    if (!too_long_i) begin
      unique case (phase_q)
        opep_pkg::PH_HEADER: begin
          if (cls_i != opep_pkg::CLS_HDR) begin
            hdr_good_d = 1'b0;
          end
          if (pos_i >= PosW'(opep_pkg::HDR_LEN - 1)) begin
            phase_d = opep_pkg::PH_TOKEN;
          end
        end
        opep_pkg::PH_TOKEN: begin
          if (cls_i == opep_pkg::CLS_BLANK) begin
            phase_d  = opep_pkg::PH_SKIP;
            pstart_d = pos_next;
          end else if (cls_i == opep_pkg::CLS_BREAK) begin
            // Newline or NUL stays in the payload.
            phase_d  = opep_pkg::PH_PAYLOAD;
            pstart_d = pos_i;
          end else begin
            if (tok_len_q < TlW'(opep_pkg::WORD_LEN)) begin
              if (cls_i != ping_exp) ping_d = 1'b0;
              if (cls_i != pong_exp) pong_d = 1'b0;
            end else begin
              ping_d = 1'b0;
              pong_d = 1'b0;
            end
            if (tok_len_q <= TlW'(opep_pkg::TOKEN_CAP)) begin
              tok_len_d = tok_len_q + TlW'(1);
            end
          end
        end
        opep_pkg::PH_SKIP: begin
          if (cls_i == opep_pkg::CLS_BLANK) begin
            pstart_d = pos_next;
          end else begin
            phase_d = opep_pkg::PH_PAYLOAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for a final byte, built from the updated state.
  always_comb begin
    limit = (max_cmd_len_i > TlW'(opep_pkg::TOKEN_CAP)) ? TlW'(opep_pkg::TOKEN_CAP)
                                                        : max_cmd_len_i;
    off_w   = (phase_d == opep_pkg::PH_TOKEN) ? pos_next : pstart_d;
    len_w   = pos_next - off_w;
    off_ext = ExtW'(off_w);
    len_ext = ExtW'(len_w);

    res_o.status         = opep_pkg::ST_UNKNOWN;
    res_o.command_id     = opep_pkg::CMD_PING;
    res_o.payload_offset = '0;
    res_o.payload_length = '0;
    if (too_long_i) begin
      res_o.status = opep_pkg::ST_TOO_LONG;
    end else if (pos_i < PosW'(opep_pkg::MIN_PACKET - 1)) begin
      res_o.status = opep_pkg::ST_UNDERSIZED;
    end else if (!hdr_good_d) begin
      res_o.status = opep_pkg::ST_NO_HEADER;
    end else if (tok_len_d == '0 || tok_len_d > limit) begin
      res_o.status = opep_pkg::ST_BAD_LENGTH;
    end else if (tok_len_d == TlW'(opep_pkg::WORD_LEN) && (ping_d || pong_d)) begin
      res_o.status         = opep_pkg::ST_OK;
      res_o.command_id     = ping_d ? opep_pkg::CMD_PING : opep_pkg::CMD_PONG;
      res_o.payload_offset = off_ext[opep_pkg::OFFSET_W-1:0];
      res_o.payload_length = len_ext[opep_pkg::OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= opep_pkg::PH_HEADER;
      hdr_good_q <= 1'b1;
      tok_len_q  <= '0;
      ping_q     <= 1'b1;
      pong_q     <= 1'b1;
      pstart_q   <= '0;
    end else if (item_pop_o) begin
      if (last_i) begin
        phase_q    <= opep_pkg::PH_HEADER;
        hdr_good_q <= 1'b1;
        tok_len_q  <= '0;
        ping_q     <= 1'b1;
        pong_q     <= 1'b1;
        pstart_q   <= '0;
      end else begin
        phase_q    <= phase_d;
        hdr_good_q <= hdr_good_d;
        tok_len_q  <= tok_len_d;
        ping_q     <= ping_d;
        pong_q     <= pong_d;
        pstart_q   <= pstart_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && last_i) |=> (phase_q == opep_pkg::PH_HEADER && tok_len_q == '0))
    else $error("packet state not cleared after final byte");

  a_tok_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_len_q <= TlW'(opep_pkg::TOKEN_CAP + 1))
    else $error("token length beyond saturation");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == opep_pkg::PH_HEADER) |-> (tok_len_q == '0 && ping_q && pong_q))
    else $error("token state touched during header");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.status != opep_pkg::ST_OK) |->
      (res_o.payload_offset == '0 && res_o.payload_length == '0))
    else $error("rejected packet carries payload fields");

endmodule
`default_nettype wire
